### rtl/core/klcs_pkg.sv
package klcs_pkg;

    localparam int HELD_DEPTH_DEF = 12;
    localparam int RULE_TOTAL     = 20;

    localparam logic [7:0] KEY_LSHIFT = 8'hE1;
    localparam logic [7:0] KEY_RSHIFT = 8'hE5;
    localparam logic [7:0] BASIC_LOW  = 8'h04;
    localparam logic [7:0] BASIC_HIGH = 8'hA4;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_REQ    = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ADD  = 2'd1;
    localparam logic [1:0] ACT_REM  = 2'd2;
    localparam logic [1:0] ACT_SEND = 2'd3;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_OFF  = 2'd1;
    localparam logic [1:0] PEND_ON   = 2'd2;

    typedef struct packed {
        logic [7:0] key;
        logic [7:0] out;
        logic       sub;
        logic       shift;
    } t_slot;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture request
        logic scan;     // walk one held entry (from the top down)
        logic rule;     // test one chord rule
        logic shift;    // move one entry down during removal
        logic finish;   // commit the step and build the result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic rule_done;
        logic shift_done;
        logic need_rule;
        logic need_shift;
    } t_stat;

    // Chord rule: {in key, in shift, out key, out shift}.
    function automatic logic [17:0] chord_rule(input logic [4:0] i);
        case (i)
            5'd0:  chord_rule = {8'h35, 1'b1, 8'h2E, 1'b1};
            5'd1:  chord_rule = {8'h1F, 1'b1, 8'h2F, 1'b0};
            5'd2:  chord_rule = {8'h23, 1'b1, 8'h2E, 1'b0};
            5'd3:  chord_rule = {8'h24, 1'b1, 8'h23, 1'b1};
            5'd4:  chord_rule = {8'h25, 1'b1, 8'h34, 1'b1};
            5'd5:  chord_rule = {8'h26, 1'b1, 8'h25, 1'b1};
            5'd6:  chord_rule = {8'h27, 1'b1, 8'h26, 1'b1};
            5'd7:  chord_rule = {8'h2D, 1'b1, 8'h87, 1'b1};
            5'd8:  chord_rule = {8'h2E, 1'b0, 8'h2D, 1'b1};
            5'd9:  chord_rule = {8'h2E, 1'b1, 8'h33, 1'b1};
            5'd10: chord_rule = {8'h2F, 1'b0, 8'h30, 1'b0};
            5'd11: chord_rule = {8'h2F, 1'b1, 8'h30, 1'b1};
            5'd12: chord_rule = {8'h30, 1'b0, 8'h32, 1'b0};
            5'd13: chord_rule = {8'h30, 1'b1, 8'h32, 1'b1};
            5'd14: chord_rule = {8'h31, 1'b0, 8'h87, 1'b0};
            5'd15: chord_rule = {8'h31, 1'b1, 8'h89, 1'b1};
            5'd16: chord_rule = {8'h33, 1'b1, 8'h34, 1'b0};
            5'd17: chord_rule = {8'h34, 1'b0, 8'h24, 1'b1};
            5'd18: chord_rule = {8'h34, 1'b1, 8'h1F, 1'b1};
            5'd19: chord_rule = {8'h35, 1'b0, 8'h2F, 1'b1};
            default: chord_rule = '1;
        endcase
    endfunction

endpackage

### rtl/core/klcs_ctrl.sv
module klcs_ctrl import klcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RULE, S_SHIFT, S_DONE, S_OUT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.need_rule) n_state = S_RULE;
                    else if (i_stat.need_shift) n_state = S_SHIFT;
                    else n_state = S_DONE;
                end
            end
            S_RULE: begin
                o_cmd.rule = 1'b1;
                if (i_stat.rule_done) n_state = S_DONE;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid == (r_state == S_OUT)) else $error("valid out of step");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready) else $error("accept while result waits");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid) else $error("finish without result");

endmodule

### rtl/core/klcs_dp.sv
module klcs_dp import klcs_pkg::*; #(
    parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_key_code,
    input  logic       i_key_down,
    input  logic       i_want_enable,
    output logic [15:0] o_result
);

    localparam int IW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int CW = $clog2(HELD_DEPTH + 1);

    t_slot          r_held [HELD_DEPTH];
    logic [CW-1:0]  r_total;
    logic [1:0]     r_phys, r_pend;
    logic           r_mode, r_win;

    logic [1:0]     r_op;
    logic [7:0]     r_key;
    logic           r_down, r_want;
    logic [CW-1:0]  r_ptr;       // scan pointer, counts down
    logic           r_found;
    logic [IW-1:0]  r_idx;
    logic           r_anysub;    // any held entry substituted
    logic           r_anysub_x;  // excluding the matched entry
    logic [4:0]     r_rule;
    logic           r_hit;
    logic [7:0]     r_rout;
    logic           r_rsh;
    logic [15:0]    r_res;
    logic           r_held_sub;
    logic [7:0]     r_held_out;

    logic key_sh, key_basic, is_press, is_rel;
    logic [CW-1:0] sp;
    logic [IW-1:0] si;
    logic [CW-1:0] idx_nx;
    logic [17:0]   rule_w;
    logic          phys_any;

    assign key_sh    = (r_key == KEY_LSHIFT) || (r_key == KEY_RSHIFT);
    assign key_basic = (r_key >= BASIC_LOW) && (r_key <= BASIC_HIGH);
    assign is_press  = (r_op == OP_KEY) && !key_sh && key_basic && r_down;
    assign is_rel    = (r_op == OP_KEY) && !key_sh && key_basic && !r_down;
    assign sp        = r_ptr - CW'(1);
    assign si        = sp[IW-1:0];
    assign idx_nx    = CW'(r_idx) + CW'(1);
    assign rule_w    = chord_rule(r_rule);
    assign phys_any  = (r_phys != 2'b00);

    // The walk always covers every held entry, so the substituted flags
    // below a matched entry are collected too.
    assign o_stat.scan_done  = (r_ptr == '0);
    assign o_stat.need_rule  = is_press && (r_total < CW'(HELD_DEPTH)) && r_mode && r_win;
    assign o_stat.need_shift = is_rel && r_found;
    assign o_stat.rule_done  = r_hit || (r_rule == 5'(RULE_TOTAL - 1));
    assign o_stat.shift_done = (idx_nx >= r_total);
    assign o_result = r_res;

    // Combined finish values.
    logic        req_mode_cur;
    logic        req_en;
    logic [CW-1:0] f_total;
    logic [1:0]  f_pend, f_phys;
    logic        f_mode, f_chg, f_pass, f_upd;
    logic [1:0]  f_act, f_shb;
    logic [7:0]  f_hkey;
    t_slot       f_top, new_slot;
    logic        push, f_anysub;

    always_comb begin
        f_total = r_total; f_pend = r_pend; f_phys = r_phys; f_mode = r_mode;
        f_chg = 1'b0; f_pass = 1'b0; f_upd = 1'b0; f_act = ACT_NONE; f_hkey = 8'h00;
        push = 1'b0;
        req_mode_cur = (r_pend != PEND_NONE) ? (r_pend == PEND_ON) : r_mode;
        req_en = (r_op == OP_TOGGLE) ? !req_mode_cur : r_want;
        new_slot.key   = r_key;
        new_slot.sub   = r_hit;
        new_slot.out   = r_hit ? r_rout : r_key;
        new_slot.shift = r_hit ? r_rsh : phys_any;
        f_anysub = r_anysub;
        case (r_op)
            OP_REQ, OP_TOGGLE: begin
                if (req_mode_cur != req_en) begin
                    if (r_total != '0) begin
                        f_pend = req_en ? PEND_ON : PEND_OFF;
                    end else begin
                        f_pend = PEND_NONE;
                        f_chg  = (r_mode != req_en);
                        f_mode = req_en;
                    end
                end
            end
            OP_CLEAR: begin
                f_total = '0;
                f_upd   = 1'b1;
            end
            default: begin
                if (key_sh) begin
                    if (r_key == KEY_LSHIFT) f_phys[0] = r_down;
                    else f_phys[1] = r_down;
                    if (!r_anysub) f_pass = 1'b1;
                    else begin
                        f_upd = 1'b1; f_act = ACT_SEND;
                    end
                end else if (!key_basic) begin
                    f_pass = 1'b1;
                end else if (r_down) begin
                    if (r_total >= CW'(HELD_DEPTH)) begin
                        f_pass = 1'b1;
                    end else begin
                        push    = 1'b1;
                        f_total = r_total + CW'(1);
                        f_anysub = r_anysub | r_hit;
                        if (!r_hit) begin
                            f_upd = f_anysub; f_pass = 1'b1;
                        end else begin
                            f_upd = 1'b1; f_act = ACT_ADD; f_hkey = r_rout;
                        end
                    end
                end else if (!r_found) begin
                    f_pass = 1'b1;
                end else begin
                    f_total = r_total - CW'(1);
                    f_anysub = r_anysub_x;
                    if (!r_held_sub) begin
                        f_upd = f_anysub; f_pass = 1'b1;
                    end else begin
                        f_upd = 1'b1; f_act = ACT_REM; f_hkey = r_held_out;
                    end
                end
            end
        endcase
        if ((r_op == OP_CLEAR || (is_rel && r_found)) && f_total == '0
            && f_pend != PEND_NONE) begin
            f_chg  = (r_mode != (f_pend == PEND_ON));
            f_mode = (f_pend == PEND_ON);
            f_pend = PEND_NONE;
        end
        if (push) f_top = new_slot;
        else if (f_total != '0) f_top = r_held[IW'(f_total - CW'(1))];
        else f_top = '0;
        // After a removal the entries have already been shifted down.
        f_shb = (f_total != '0 && f_top.sub) ? {1'b0, f_top.shift} : f_phys;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0; r_phys <= '0; r_pend <= PEND_NONE;
            r_mode <= 1'b0; r_win <= 1'b0;
        end else begin
            if (i_cfg_we) r_win <= i_cfg_wdata;
            if (i_cmd.finish) begin
                r_total <= f_total; r_phys <= f_phys; r_pend <= f_pend;
                r_mode  <= f_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation; r_key <= i_key_code;
            r_down <= i_key_down; r_want <= i_want_enable;
            r_ptr <= r_total; r_found <= 1'b0;
            r_anysub <= 1'b0; r_anysub_x <= 1'b0;
            r_rule <= '0; r_hit <= 1'b0;
        end
        if (i_cmd.scan && r_ptr != '0) begin
            r_ptr <= sp;
            r_anysub <= r_anysub | r_held[si].sub;
            if (is_rel && !r_found && r_held[si].key == r_key) begin
                r_found <= 1'b1; r_idx <= si;
                r_held_sub <= r_held[si].sub; r_held_out <= r_held[si].out;
            end else begin
                r_anysub_x <= r_anysub_x | r_held[si].sub;
            end
        end
        if (i_cmd.rule && !r_hit) begin
            if (rule_w[17:10] == r_key && rule_w[9] == phys_any) begin
                r_hit <= 1'b1; r_rout <= rule_w[8:1]; r_rsh <= rule_w[0];
            end else begin
                r_rule <= r_rule + 5'd1;
            end
        end
        if (i_cmd.shift) begin
            if (!o_stat.shift_done) begin
                r_held[r_idx] <= r_held[IW'(idx_nx)];
                r_idx <= IW'(idx_nx);
            end
        end
        if (i_cmd.finish) begin
            if (push) r_held[IW'(r_total)] <= new_slot;
            r_res <= {f_chg, f_mode, f_shb, f_hkey, f_act, f_upd, f_pass};
        end
    end

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(HELD_DEPTH)) else $error("held count overflow");
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0 && $past(i_cmd.finish)) |-> r_pend == PEND_NONE)
        else $error("pending mode left while idle");
    a_found_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> r_found) else $error("shift without match");

endmodule

### rtl/core/keyboard_layout_chord_substituter.sv
// Channel  | Signals                            | Meaning
// s_axis   | tvalid tready tdata[15:0]          | one request in
// m_axis   | tvalid tready tdata[7:0] tuser[7:0]| one result out
// cfg      | i_cfg_we i_cfg_wdata               | windows_host register
// A request is walked after acceptance: a walk over the held entries from the top
// down, then chord-rule tests for a press when the mode and the host register
// allow it and the stack has room, or a shift of the later entries down for a
// release that found its key, then a commit step that raises the result.
// One request is in flight at a time; s_axis_tready returns the cycle after
// the result is accepted, so m_axis_tready stalls hold off the next request.
// Reset is synchronous, active low, and empties the held stack.
module keyboard_layout_chord_substituter import klcs_pkg::*; #(
    parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], key_code[9:2], key_down[10], want_enable[11]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // host_key[7:0]
    output logic [7:0]  m_axis_tdata,
    // pass_through[0], shift_update[1], report_action[3:2], shift_bits[5:4],
    // mode_now[6], mode_changed[7]
    output logic [7:0]  m_axis_tuser
);

    t_cmd        cmd;
    t_stat       stat;
    logic [15:0] res;

    klcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    klcs_dp #(.HELD_DEPTH(HELD_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_cmd(cmd), .o_stat(stat),
        .i_operation(s_axis_tdata[1:0]), .i_key_code(s_axis_tdata[9:2]),
        .i_key_down(s_axis_tdata[10]), .i_want_enable(s_axis_tdata[11]),
        .o_result(res)
    );

    assign m_axis_tdata = res[11:4];
    assign m_axis_tuser = {res[15:12], res[3:0]};

endmodule

### bench/tb_keyboard_layout_chord_substituter.sv
module tb_keyboard_layout_chord_substituter;
    timeunit 1ns;
    timeprecision 1ps;
    import klcs_pkg::*;

    localparam int STACK_DEPTH = HELD_DEPTH_DEF;
    localparam int CHORD_TOTAL = 20;
    localparam logic [7:0] KC_A = 8'h04;

    typedef struct packed {
        logic       mode_changed;
        logic       mode_now;
        logic [1:0] shift_bits;
        logic [7:0] host_key;
        logic [1:0] report_action;
        logic       shift_update;
        logic       pass_through;
    } t_outcome;

    typedef struct {
        logic [1:0] op;
        logic [7:0] key;
        logic       down;
        logic       want;
        logic       typed;     // expected result given in the row
        t_outcome   outcome;
    } t_row;

    typedef struct {
        logic [7:0] key;
        logic [7:0] out;
        logic       sub;
        logic       shift;
    } t_held;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [7:0] m_axis_tuser;

    keyboard_layout_chord_substituter u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    logic       win_host;
    t_held      stack_q[STACK_DEPTH];
    int         stack_n;
    logic [1:0] shift_keys;
    logic [1:0] pend_mode;
    logic       subst_on;
    logic       mode_flip;

    t_outcome   expected_q[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function automatic logic [17:0] chord_entry(int i);
        logic [17:0] r;
        case (i)
            0:  r = {8'h35, 1'b1, 8'h2E, 1'b1};
            1:  r = {8'h1F, 1'b1, 8'h2F, 1'b0};
            2:  r = {8'h23, 1'b1, 8'h2E, 1'b0};
            3:  r = {8'h24, 1'b1, 8'h23, 1'b1};
            4:  r = {8'h25, 1'b1, 8'h34, 1'b1};
            5:  r = {8'h26, 1'b1, 8'h25, 1'b1};
            6:  r = {8'h27, 1'b1, 8'h26, 1'b1};
            7:  r = {8'h2D, 1'b1, 8'h87, 1'b1};
            8:  r = {8'h2E, 1'b0, 8'h2D, 1'b1};
            9:  r = {8'h2E, 1'b1, 8'h33, 1'b1};
            10: r = {8'h2F, 1'b0, 8'h30, 1'b0};
            11: r = {8'h2F, 1'b1, 8'h30, 1'b1};
            12: r = {8'h30, 1'b0, 8'h32, 1'b0};
            13: r = {8'h30, 1'b1, 8'h32, 1'b1};
            14: r = {8'h31, 1'b0, 8'h87, 1'b0};
            15: r = {8'h31, 1'b1, 8'h89, 1'b1};
            16: r = {8'h33, 1'b1, 8'h34, 1'b0};
            17: r = {8'h34, 1'b0, 8'h24, 1'b1};
            18: r = {8'h34, 1'b1, 8'h1F, 1'b1};
            default: r = {8'h35, 1'b0, 8'h2F, 1'b1};
        endcase
        return r;
    endfunction

    function automatic logic holds_substitute();
        for (int i = 0; i < stack_n; i++)
            if (stack_q[i].sub) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic desired_mode();
        if (pend_mode != PEND_NONE) return pend_mode == PEND_ON;
        return subst_on;
    endfunction

    function automatic void set_mode(logic en);
        if (subst_on != en) begin
            subst_on = en;
            mode_flip = 1'b1;
        end
    endfunction

    function automatic void ask_mode(logic en);
        if (desired_mode() == en) return;
        if (stack_n != 0) begin
            pend_mode = en ? PEND_ON : PEND_OFF;
        end else begin
            pend_mode = PEND_NONE;
            set_mode(en);
        end
    endfunction

    function automatic void settle_pending();
        if (stack_n == 0 && pend_mode != PEND_NONE) begin
            logic en;
            en = pend_mode == PEND_ON;
            pend_mode = PEND_NONE;
            set_mode(en);
        end
    endfunction

    function automatic t_outcome substitute_step(logic [1:0] op, logic [7:0] key,
                                                 logic down, logic want);
        t_outcome o;
        int hit;
        int idx;
        logic sh;
        logic [17:0] r;
        o = '0;
        mode_flip = 1'b0;
        if (op == OP_REQ) begin
            ask_mode(want);
        end else if (op == OP_TOGGLE) begin
            ask_mode(!desired_mode());
        end else if (op == OP_CLEAR) begin
            stack_n = 0;
            o.shift_update = 1'b1;
            settle_pending();
        end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
            if (down) shift_keys |= (key == KEY_LSHIFT) ? 2'b01 : 2'b10;
            else shift_keys &= (key == KEY_LSHIFT) ? 2'b10 : 2'b01;
            if (!holds_substitute()) begin
                o.pass_through = 1'b1;
            end else begin
                o.shift_update = 1'b1;
                o.report_action = ACT_SEND;
            end
        end else if (key < BASIC_LOW || key > BASIC_HIGH) begin
            o.pass_through = 1'b1;
        end else if (down) begin
            if (stack_n >= STACK_DEPTH) begin
                o.pass_through = 1'b1;
            end else begin
                sh = shift_keys != 0;
                hit = -1;
                if (subst_on && win_host)
                    for (int i = CHORD_TOTAL - 1; i >= 0; i--) begin
                        r = chord_entry(i);
                        if (r[17:10] == key && r[9] == sh) hit = i;
                    end
                stack_q[stack_n].key = key;
                stack_q[stack_n].sub = hit >= 0;
                if (hit >= 0) begin
                    r = chord_entry(hit);
                    stack_q[stack_n].out = r[8:1];
                    stack_q[stack_n].shift = r[0];
                end else begin
                    stack_q[stack_n].out = key;
                    stack_q[stack_n].shift = sh;
                end
                stack_n++;
                if (hit < 0) begin
                    o.shift_update = holds_substitute();
                    o.pass_through = 1'b1;
                end else begin
                    o.shift_update = 1'b1;
                    o.report_action = ACT_ADD;
                    o.host_key = r[8:1];
                end
            end
        end else begin
            idx = -1;
            for (int i = stack_n - 1; i >= 0 && idx < 0; i--)
                if (stack_q[i].key == key) idx = i;
            if (idx < 0) begin
                o.pass_through = 1'b1;
            end else begin
                t_held gone;
                gone = stack_q[idx];
                for (int i = idx; i + 1 < stack_n; i++) stack_q[i] = stack_q[i + 1];
                stack_n--;
                if (!gone.sub) begin
                    o.shift_update = holds_substitute();
                    o.pass_through = 1'b1;
                end else begin
                    o.shift_update = 1'b1;
                    o.report_action = ACT_REM;
                    o.host_key = gone.out;
                end
                settle_pending();
            end
        end
        if (stack_n > 0 && stack_q[stack_n - 1].sub)
            o.shift_bits = {1'b0, stack_q[stack_n - 1].shift};
        else
            o.shift_bits = shift_keys;
        o.mode_now = subst_on;
        o.mode_changed = mode_flip;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", int'(m_axis_tuser), 0);
            end else begin
                t_outcome e;
                t_outcome g;
                e = expected_q.pop_front();
                g = {m_axis_tuser[7:4], m_axis_tdata, m_axis_tuser[3:0]};
                if (g.pass_through !== e.pass_through)
                    report_mismatch("pass_through", int'(g.pass_through),
                                    int'(e.pass_through));
                if (g.shift_update !== e.shift_update)
                    report_mismatch("shift_update", int'(g.shift_update),
                                    int'(e.shift_update));
                if (g.report_action !== e.report_action)
                    report_mismatch("report_action", int'(g.report_action),
                                    int'(e.report_action));
                if (g.host_key !== e.host_key)
                    report_mismatch("host_key", int'(g.host_key), int'(e.host_key));
                if (g.shift_bits !== e.shift_bits)
                    report_mismatch("shift_bits", int'(g.shift_bits), int'(e.shift_bits));
                if (g.mode_now !== e.mode_now)
                    report_mismatch("mode_now", int'(g.mode_now), int'(e.mode_now));
                if (g.mode_changed !== e.mode_changed)
                    report_mismatch("mode_changed", int'(g.mode_changed),
                                    int'(e.mode_changed));
            end
        end
    end

    // Receiver stalls, redrawn each cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The valid stays high after acceptance until the next request or an idle
    // gap replaces it; the block is not ready again that soon.
    task automatic send_request(logic [1:0] op, logic [7:0] key, logic down, logic want,
                                logic typed, t_outcome outcome);
        t_outcome p;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata <= {4'b0, want, down, key, op};
        s_axis_tvalid <= 1'b1;
        p = substitute_step(op, key, down, want);
        if (typed && p != outcome) report_mismatch("table row", int'(p), int'(outcome));
        expected_q.push_back(p);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_host(logic v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        win_host = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_key();
        int k;
        logic [17:0] r;
        k = $urandom_range(99);
        if (k < 55) begin
            r = chord_entry($urandom_range(CHORD_TOTAL - 1));
            return r[17:10];
        end
        if (k < 70) return $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
        if (k < 90) return 8'($urandom_range(8'hA4, 8'h04));
        return 8'($urandom_range(255));
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        logic [7:0] held_keys[$];
        logic [7:0] k;
        int c;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            c = $urandom_range(99);
            if (c < 4) begin
                send_request(OP_REQ, 8'($urandom), 1'($urandom), 1'($urandom), 0, '0);
            end else if (c < 7) begin
                send_request(OP_TOGGLE, 8'($urandom), 1'($urandom), 1'($urandom), 0, '0);
            end else if (c < 9) begin
                send_request(OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 0, '0);
                held_keys.delete();
            end else if (c < 55 || held_keys.size() == 0) begin
                k = pick_key();
                held_keys.push_back(k);
                send_request(OP_KEY, k, 1'b1, 1'($urandom), 0, '0);
            end else if (c < 92) begin
                int j;
                j = $urandom_range(held_keys.size() - 1);
                k = held_keys[j];
                held_keys.delete(j);
                send_request(OP_KEY, k, 1'b0, 1'($urandom), 0, '0);
            end else begin
                send_request(OP_KEY, pick_key(), 1'b0, 1'($urandom), 0, '0);
            end
        end
        send_idle_pct = 0;
    endtask

    initial begin
        t_row rows[$];
        t_outcome z;
        z = '0;
        win_host = 1'b0;
        stack_n = 0;
        shift_keys = '0;
        pend_mode = PEND_NONE;
        subst_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; typed outcome only where it is obvious.
        rows.push_back('{OP_KEY, 8'h00, 1'b1, 1'b0, 1'b1, '{0, 0, 2'b00, 8'h00, ACT_NONE, 0, 1}});
        rows.push_back('{OP_KEY, 8'hFF, 1'b0, 1'b1, 1'b1, '{0, 0, 2'b00, 8'h00, ACT_NONE, 0, 1}});
        rows.push_back('{OP_KEY, KC_A, 1'b0, 1'b0, 1'b1, '{0, 0, 2'b00, 8'h00, ACT_NONE, 0, 1}});
        rows.push_back('{OP_REQ, 8'h00, 1'b0, 1'b1, 1'b1, '{1, 1, 2'b00, 8'h00, ACT_NONE, 0, 0}});
        rows.push_back('{OP_REQ, 8'h00, 1'b0, 1'b1, 1'b1, '{0, 1, 2'b00, 8'h00, ACT_NONE, 0, 0}});
        rows.push_back('{OP_KEY, 8'h35, 1'b1, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, KEY_LSHIFT, 1'b1, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, 8'h35, 1'b1, 1'b0, 1'b0, z});
        rows.push_back('{OP_TOGGLE, 8'h00, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, 8'h35, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, KEY_RSHIFT, 1'b1, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, 8'hA4, 1'b1, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, KEY_LSHIFT, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, KEY_RSHIFT, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, 8'h35, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, 8'hA4, 1'b0, 1'b0, 1'b0, z});
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            rows.push_back('{OP_KEY, 8'(8'h04 + i), 1'b1, 1'b0, 1'b0, z});
        rows.push_back('{OP_KEY, 8'h10, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_TOGGLE, 8'h00, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, z});
        rows.push_back('{OP_REQ, 8'hFF, 1'b1, 1'b0, 1'b0, z});

        write_host(1'b1);
        foreach (rows[i])
            send_request(rows[i].op, rows[i].key, rows[i].down, rows[i].want,
                         rows[i].typed, rows[i].outcome);

        // The sender holds off here until every result has come back.
        drain();
        random_phase(300, 0, 0);
        write_host(1'b0);
        random_phase(150, 78, 0);
        write_host(1'b1);
        random_phase(250, 0, 78);
        random_phase(320, 6, 6);
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
